FILE: rtl/periodic_task_release_table_defines.svh
// ---------------------------------------------------------------------------
// periodic task release table: assertion macros
// shared property forms, clocked on clock and disabled during reset
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_RELEASE_TABLE_DEFINES_SVH
`define PERIODIC_TASK_RELEASE_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PTRT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PTRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ptrt_pkg.sv
// ---------------------------------------------------------------------------
// ptrt_pkg
// types and fixed constants of the periodic task release table
// ---------------------------------------------------------------------------
package ptrt_pkg;

   // operation codes of a request word
   localparam logic [2:0] OP_RUN     = 3'd0;
   localparam logic [2:0] OP_ADD     = 3'd1;
   localparam logic [2:0] OP_REMOVE  = 3'd2;
   localparam logic [2:0] OP_SET_EN  = 3'd3;
   localparam logic [2:0] OP_SET_PER = 3'd4;

   // status codes of a response word
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   // most release words reported by one run
   localparam int RESULT_CAP = 16;
   localparam int CAP_W      = $clog2(RESULT_CAP + 1);

   // one table entry as stored in the memory
   typedef struct packed {
      logic [7:0]  tag;
      logic [31:0] period;
      logic [31:0] release_time;
      logic        enable;
   } entry_type;

   // one response word
   typedef struct packed {
      logic       status;
      logic       fired;
      logic [3:0] result_index;
      logic [7:0] result_tag;
      logic [4:0] entry_count;
      logic       last;
   } rsp_type;

   // response word held back until its position in the stream is known
   typedef struct packed {
      logic       status;
      logic       fired;
      logic [3:0] result_index;
      logic [7:0] result_tag;
   } pend_type;

endpackage

FILE: rtl/ptrt_req_if.sv
// ---------------------------------------------------------------------------
// ptrt_req_if
// request channel: valid/ready handshake with one operation word
// ---------------------------------------------------------------------------
interface ptrt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] now;
   logic [7:0]  task_tag;
   logic [31:0] period;
   logic [3:0]  slot;
   logic        enable_value;

   modport source (
      output valid, op, now, task_tag, period, slot, enable_value,
      input  ready
   );
   modport sink (
      input  valid, op, now, task_tag, period, slot, enable_value,
      output ready
   );
endinterface

FILE: rtl/ptrt_rsp_if.sv
// ---------------------------------------------------------------------------
// ptrt_rsp_if
// response channel: valid/ready handshake with one result word
// ---------------------------------------------------------------------------
interface ptrt_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic       fired;
   logic [3:0] result_index;
   logic [7:0] result_tag;
   logic [4:0] entry_count;
   logic       last;

   modport source (
      output valid, status, fired, result_index, result_tag, entry_count, last,
      input  ready
   );
   modport sink (
      input  valid, status, fired, result_index, result_tag, entry_count, last,
      output ready
   );
endinterface

FILE: rtl/ptrt_mem.sv
// ---------------------------------------------------------------------------
// ptrt_mem
// task table storage: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module ptrt_mem #(
   parameter int MAX_ENTRIES = 16,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  ptrt_pkg::entry_type wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output ptrt_pkg::entry_type rd_data
);

   ptrt_pkg::entry_type mem_ff [MAX_ENTRIES];
   ptrt_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ptrt_seq.sv
// ---------------------------------------------------------------------------
// ptrt_seq
// operation sequencer: walks the table memory for run and remove, applies
// add and set in place, and drives the registered response word
// ---------------------------------------------------------------------------
module ptrt_seq #(
   parameter int MAX_ENTRIES = 16,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4
) (
   input  logic                clock,
   input  logic                reset,
   ptrt_req_if.sink            req_ch,
   ptrt_rsp_if.source          rsp_ch,
   output logic                mem_wr_en,
   output logic [IDX_W-1:0]    mem_wr_addr,
   output ptrt_pkg::entry_type mem_wr_data,
   output logic [IDX_W-1:0]    mem_rd_addr,
   input  ptrt_pkg::entry_type mem_rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SET,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type                    state_ff;
   logic [IDX_W-1:0]             ptr_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [2:0]                   op_ff;
   logic [31:0]                  now_ff;
   logic [31:0]                  period_ff;
   logic                         enable_ff;
   ptrt_pkg::pend_type           pend_ff;
   logic                         pend_valid_ff;
   logic [ptrt_pkg::CAP_W-1:0]   sent_ff;
   logic                         rsp_valid_ff;
   ptrt_pkg::rsp_type            rsp_data_ff;

   logic                         out_free;
   logic [CMP_W-1:0]             slot_wide;
   logic [IDX_W-1:0]             slot_idx;
   logic                         slot_ok;
   logic                         table_full;
   logic [31:0]                  due_time;
   logic                         due;
   logic                         report;
   logic                         scan_stall;
   logic                         scan_end;
   logic                         shift_end;
   logic                         remove_top;

   // handshake and index checks
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign slot_wide  = CMP_W'(req_ch.slot);
   assign slot_idx   = slot_wide[IDX_W-1:0];
   assign slot_ok    = slot_wide < CMP_W'(count_ff);
   assign table_full = count_ff >= CNT_W'(MAX_ENTRIES);
   assign remove_top = (slot_wide + CMP_W'(1)) == CMP_W'(count_ff);

   // release test on the entry under the scan pointer, sum wraps at 32 bits
   assign due_time   = mem_rd_data.release_time + mem_rd_data.period;
   assign due        = mem_rd_data.enable && (mem_rd_data.tag != 8'd0) &&
                       (now_ff >= due_time);
   assign report     = due && (sent_ff < ptrt_pkg::CAP_W'(ptrt_pkg::RESULT_CAP));
   assign scan_stall = report && pend_valid_ff && !out_free;
   assign scan_end   = (CNT_W'(ptr_ff) + CNT_W'(1)) == count_ff;
   assign shift_end  = (CNT_W'(ptr_ff) + CNT_W'(2)) == count_ff;

   // memory read address
   always_comb begin
      mem_rd_addr = ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            unique case (req_ch.op)
               ptrt_pkg::OP_REMOVE:  mem_rd_addr = slot_idx + IDX_W'(1);
               ptrt_pkg::OP_SET_EN,
               ptrt_pkg::OP_SET_PER: mem_rd_addr = slot_idx;
               default:              mem_rd_addr = '0;
            endcase
         end
         ST_SCAN:  mem_rd_addr = scan_stall ? ptr_ff : ptr_ff + IDX_W'(1);
         ST_SHIFT: mem_rd_addr = ptr_ff + IDX_W'(2);
         default:  mem_rd_addr = ptr_ff;
      endcase
   end

   // memory write port
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff;
      mem_wr_data = mem_rd_data;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && (req_ch.op == ptrt_pkg::OP_ADD) &&
                (req_ch.task_tag != 8'd0) && !table_full) begin
               mem_wr_en                = 1'b1;
               mem_wr_addr              = count_ff[IDX_W-1:0];
               mem_wr_data.tag          = req_ch.task_tag;
               mem_wr_data.period       = req_ch.period;
               mem_wr_data.release_time = 32'd0;
               mem_wr_data.enable       = 1'b1;
            end
         end
         ST_SCAN: begin
            mem_wr_en                = due && !scan_stall;
            mem_wr_data.release_time = now_ff;
         end
         ST_SET: begin
            mem_wr_en = 1'b1;
            if (op_ff == ptrt_pkg::OP_SET_EN) begin
               mem_wr_data.enable = enable_ff;
            end else begin
               mem_wr_data.period = period_ff;
            end
         end
         ST_SHIFT: mem_wr_en = 1'b1;
         default:  mem_wr_en = 1'b0;
      endcase
   end

   // sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  op_ff         <= req_ch.op;
                  now_ff        <= req_ch.now;
                  period_ff     <= req_ch.period;
                  enable_ff     <= req_ch.enable_value;
                  ptr_ff        <= slot_idx;
                  pend_ff       <= '0;
                  pend_valid_ff <= 1'b0;
                  sent_ff       <= '0;
                  state_ff      <= ST_FINISH;
                  unique case (req_ch.op)
                     ptrt_pkg::OP_RUN: begin
                        ptr_ff <= '0;
                        if (count_ff != '0) begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     ptrt_pkg::OP_ADD: begin
                        if ((req_ch.task_tag == 8'd0) || table_full) begin
                           pend_ff.status <= ptrt_pkg::STATUS_REJECTED;
                        end else begin
                           pend_ff.result_index <= 4'(count_ff);
                           count_ff             <= count_ff + CNT_W'(1);
                        end
                     end
                     ptrt_pkg::OP_REMOVE: begin
                        if (!slot_ok) begin
                           pend_ff.status <= ptrt_pkg::STATUS_REJECTED;
                        end else if (remove_top) begin
                           count_ff <= count_ff - CNT_W'(1);
                        end else begin
                           state_ff <= ST_SHIFT;
                        end
                     end
                     ptrt_pkg::OP_SET_EN,
                     ptrt_pkg::OP_SET_PER: begin
                        if (!slot_ok) begin
                           pend_ff.status <= ptrt_pkg::STATUS_REJECTED;
                        end else begin
                           state_ff <= ST_SET;
                        end
                     end
                     default: pend_ff.status <= ptrt_pkg::STATUS_REJECTED;
                  endcase
               end
            end
            ST_SCAN: begin
               if (!scan_stall) begin
                  // a new release pushes the one held back, which is then not final
                  if (report) begin
                     if (pend_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= '{status: pend_ff.status, fired: pend_ff.fired,
                                          result_index: pend_ff.result_index,
                                          result_tag: pend_ff.result_tag,
                                          entry_count: 5'(count_ff), last: 1'b0};
                     end
                     pend_ff       <= '{status: ptrt_pkg::STATUS_OK, fired: 1'b1,
                                        result_index: 4'(ptr_ff),
                                        result_tag: mem_rd_data.tag};
                     pend_valid_ff <= 1'b1;
                     sent_ff       <= sent_ff + ptrt_pkg::CAP_W'(1);
                  end
                  if (scan_end) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     ptr_ff <= ptr_ff + IDX_W'(1);
                  end
               end
            end
            ST_SET: state_ff <= ST_FINISH;
            ST_SHIFT: begin
               if (shift_end) begin
                  count_ff <= count_ff - CNT_W'(1);
                  state_ff <= ST_FINISH;
               end else begin
                  ptr_ff <= ptr_ff + IDX_W'(1);
               end
            end
            ST_FINISH: begin
               // final word of the item, or the idle word of an empty run
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{status: pend_ff.status, fired: pend_ff.fired,
                                    result_index: pend_ff.result_index,
                                    result_tag: pend_ff.result_tag,
                                    entry_count: 5'(count_ff), last: 1'b1};
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // response channel
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_data_ff.status;
   assign rsp_ch.fired        = rsp_data_ff.fired;
   assign rsp_ch.result_index = rsp_data_ff.result_index;
   assign rsp_ch.result_tag   = rsp_data_ff.result_tag;
   assign rsp_ch.entry_count  = rsp_data_ff.entry_count;
   assign rsp_ch.last         = rsp_data_ff.last;

endmodule

FILE: rtl/periodic_task_release_table.sv
// ---------------------------------------------------------------------------
// periodic_task_release_table
// packed table of periodic tasks with add, remove, set enable, set period
// and run; run reports every enabled entry whose period has elapsed
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake        word
//   req_ch    in          valid / ready    op, now, task_tag, period, slot,
//                                          enable_value
//   rsp_ch    out         valid / ready    status, fired, result_index,
//                                          result_tag, entry_count, last
//
// one word at a time; the sequencer walks the table memory one entry a cycle,
// holding while a release waits on a full response register; run visits each
// entry, remove shifts the entries above the slot down, set enable and set
// period rewrite one entry, add writes directly; the final word waits on a full
// response register; reset clears the entry count, not the memory, and entries
// above the count go unused; a new word is taken while the last response waits
//
`include "periodic_task_release_table_defines.svh"

module periodic_task_release_table #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   ptrt_req_if.sink   req_ch,
   ptrt_rsp_if.source rsp_ch
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   ptrt_pkg::entry_type mem_wr_data;
   logic [IDX_W-1:0]    mem_rd_addr;
   ptrt_pkg::entry_type mem_rd_data;

   // operation sequencer and response register
   ptrt_seq #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // task table memory
   ptrt_mem #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // release words are never rejections and carry a real tag
   `PTRT_ASSERT_SAME(a_fired_ok, rsp_ch.valid && rsp_ch.fired, !rsp_ch.status && (rsp_ch.result_tag != 8'd0), "release word rejected or tagless")
   // only releases may be followed by more words of the same item
   `PTRT_ASSERT_SAME(a_nonlast_fired, rsp_ch.valid && !rsp_ch.last, rsp_ch.fired, "non-final word is not a release")
   // a table write while idle only comes with an accepted add
   `PTRT_ASSERT_SAME(a_idle_write, mem_wr_en && req_ch.ready, req_ch.valid, "table written while idle without a word")
   // the block is busy in the cycle after it takes a word
   `PTRT_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready, "ready right after accept")

endmodule

FILE: bench/ptrt_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptrt_checker
// watches the request and response channels of the task release table,
// keeps its own copy of the table, predicts every response word and
// compares each accepted word field by field with the oldest prediction
// ---------------------------------------------------------------------------
module ptrt_checker #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic clock,
   input  logic reset,
   ptrt_req_if  req_ch,
   ptrt_rsp_if  rsp_ch,
   output int   error_count,
   output int   pending_words
);

   // shadow of the task table
   ptrt_pkg::entry_type task_tbl [MAX_ENTRIES];
   logic [4:0]          used_count;

   // response words still owed by the block, oldest first
   ptrt_pkg::rsp_type   expected_words [$];
   ptrt_pkg::rsp_type   want;
   int                  mismatches;

   function automatic ptrt_pkg::rsp_type make_word(input logic status, input logic fired,
                                                   input logic [3:0] index,
                                                   input logic [7:0] tag,
                                                   input logic is_last);
      ptrt_pkg::rsp_type w;
      w.status       = status;
      w.fired        = fired;
      w.result_index = index;
      w.result_tag   = tag;
      w.entry_count  = used_count;
      w.last         = is_last;
      return w;
   endfunction

   // apply one request word to the shadow table and queue its responses
   task automatic predict_words(input logic [2:0] op, input logic [31:0] now,
                                input logic [7:0] tag, input logic [31:0] period,
                                input logic [3:0] slot, input logic en);
      ptrt_pkg::rsp_type held;
      bit                have_held;
      int                reported;
      logic [31:0]       due;
      have_held = 1'b0;
      reported  = 0;
      case (op)
         ptrt_pkg::OP_RUN: begin
            // release scan; the last release word is held back to mark it last
            for (int i = 0; i < used_count; i++) begin
               due = task_tbl[i].release_time + task_tbl[i].period;
               if (task_tbl[i].enable && task_tbl[i].tag != 8'd0 && now >= due) begin
                  task_tbl[i].release_time = now;
                  if (reported < ptrt_pkg::RESULT_CAP) begin
                     if (have_held)
                        expected_words.push_back(held);
                     held = make_word(ptrt_pkg::STATUS_OK, 1'b1, 4'(i),
                                      task_tbl[i].tag, 1'b0);
                     have_held = 1'b1;
                     reported++;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               expected_words.push_back(held);
            end else begin
               expected_words.push_back(make_word(ptrt_pkg::STATUS_OK, 1'b0, 4'd0,
                                                  8'd0, 1'b1));
            end
         end
         ptrt_pkg::OP_ADD: begin
            // null tag or full table is refused
            if (tag == 8'd0 || used_count >= MAX_ENTRIES) begin
               expected_words.push_back(make_word(ptrt_pkg::STATUS_REJECTED, 1'b0, 4'd0,
                                                  8'd0, 1'b1));
            end else begin
               task_tbl[used_count].tag          = tag;
               task_tbl[used_count].period       = period;
               task_tbl[used_count].release_time = 32'd0;
               task_tbl[used_count].enable       = 1'b1;
               used_count++;
               expected_words.push_back(make_word(ptrt_pkg::STATUS_OK, 1'b0,
                                                  4'(used_count - 1), 8'd0, 1'b1));
            end
         end
         ptrt_pkg::OP_REMOVE, ptrt_pkg::OP_SET_EN, ptrt_pkg::OP_SET_PER: begin
            if (5'(slot) >= used_count) begin
               expected_words.push_back(make_word(ptrt_pkg::STATUS_REJECTED, 1'b0, 4'd0,
                                                  8'd0, 1'b1));
            end else begin
               if (op == ptrt_pkg::OP_REMOVE) begin
                  // close the gap and clear the top entry
                  for (int i = slot; i + 1 < used_count; i++)
                     task_tbl[i] = task_tbl[i + 1];
                  task_tbl[used_count - 1] = '0;
                  used_count--;
               end else if (op == ptrt_pkg::OP_SET_EN) begin
                  task_tbl[slot].enable = en;
               end else begin
                  task_tbl[slot].period = period;
               end
               expected_words.push_back(make_word(ptrt_pkg::STATUS_OK, 1'b0, 4'd0,
                                                  8'd0, 1'b1));
            end
         end
         default: begin
            expected_words.push_back(make_word(ptrt_pkg::STATUS_REJECTED, 1'b0, 4'd0,
                                               8'd0, 1'b1));
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t ptrt_checker: %s expected %0h actual %0h",
                  $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // response side first, then the request accepted at the same edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++)
            task_tbl[i] = '0;
         used_count = 5'd0;
         expected_words.delete();
         mismatches = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t ptrt_checker: word expected none actual %0h/%0h/%0h/%0h/%0h/%0h",
                        $time, rsp_ch.status, rsp_ch.fired, rsp_ch.result_index,
                        rsp_ch.result_tag, rsp_ch.entry_count, rsp_ch.last);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               compare_field("status", want.status, rsp_ch.status);
               compare_field("fired", want.fired, rsp_ch.fired);
               compare_field("result_index", want.result_index, rsp_ch.result_index);
               compare_field("result_tag", want.result_tag, rsp_ch.result_tag);
               compare_field("entry_count", want.entry_count, rsp_ch.entry_count);
               compare_field("last", want.last, rsp_ch.last);
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_words(req_ch.op, req_ch.now, req_ch.task_tag, req_ch.period,
                          req_ch.slot, req_ch.enable_value);
      end
      error_count   <= mismatches;
      pending_words <= expected_words.size();
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// drives request words into the task release table, takes its response
// words with random and long stalls, and reports the checker's verdict
// ---------------------------------------------------------------------------
module tb;

   logic        clock;
   logic        reset;
   int          error_count;
   int          pending_words;
   int          send_idle_pct;
   int          take_idle_pct;
   bit          hold_toggle;
   logic [31:0] sim_ms;

   ptrt_req_if req_ch ();
   ptrt_rsp_if rsp_ch ();

   periodic_task_release_table DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ptrt_checker table_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .error_count   (error_count),
      .pending_words (pending_words)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("tb: errors");
      $finish;
   end

   // response taker: random stalls, plus one long hold-off on request
   initial begin
      bit seen;
      seen = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen) begin
            seen = hold_toggle;
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // offer one request word, with random gaps before it
   task automatic send_word(input logic [2:0] op, input logic [31:0] now,
                            input logic [7:0] tag, input logic [31:0] period,
                            input logic [3:0] slot, input logic en);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.now          <= now;
      req_ch.task_tag     <= tag;
      req_ch.period       <= period;
      req_ch.slot         <= slot;
      req_ch.enable_value <= en;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // mostly well-formed table traffic with a running millisecond clock
   task automatic send_random_word();
      int          pick;
      logic [2:0]  op;
      logic [31:0] now;
      logic [31:0] period;
      logic [7:0]  tag;
      logic [3:0]  slot;
      pick = $urandom_range(99);
      if (pick < 40)
         op = ptrt_pkg::OP_RUN;
      else if (pick < 60)
         op = ptrt_pkg::OP_ADD;
      else if (pick < 70)
         op = ptrt_pkg::OP_REMOVE;
      else if (pick < 82)
         op = ptrt_pkg::OP_SET_EN;
      else if (pick < 95)
         op = ptrt_pkg::OP_SET_PER;
      else
         op = 3'(ptrt_pkg::OP_SET_PER + $urandom_range(1, 3));
      // time mostly creeps forward, sometimes jumps anywhere
      sim_ms = sim_ms + $urandom_range(0, 40);
      if ($urandom_range(19) == 0)
         sim_ms = $urandom;
      now = ($urandom_range(9) == 0) ? $urandom : sim_ms;
      case ($urandom_range(9))
         7:       period = $urandom;
         8:       period = 32'hFFFF_FFFF - $urandom_range(0, 60);
         9:       period = 32'd0;
         default: period = $urandom_range(0, 60);
      endcase
      tag  = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      slot = $urandom_range(1) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(0, 15));
      send_word(op, now, tag, period, slot, ($urandom_range(3) != 0));
   endtask

   initial begin
      int guard;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.op           <= ptrt_pkg::OP_RUN;
      req_ch.now          <= 32'd0;
      req_ch.task_tag     <= 8'd0;
      req_ch.period       <= 32'd0;
      req_ch.slot         <= 4'd0;
      req_ch.enable_value <= 1'b0;
      send_idle_pct       <= 24;
      take_idle_pct       <= 85;
      hold_toggle         <= 1'b0;
      sim_ms = 32'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table: idle run and refused commands
      send_word(ptrt_pkg::OP_RUN, 32'd0, 8'd0, 32'd0, 4'd0, 1'b0);
      send_word(ptrt_pkg::OP_REMOVE, 32'd0, 8'd0, 32'd0, 4'd0, 1'b0);
      send_word(ptrt_pkg::OP_ADD, 32'd0, 8'd0, 32'd5, 4'd0, 1'b1);
      send_word(3'(ptrt_pkg::OP_SET_PER + 1), 32'd0, 8'd3, 32'd0, 4'd0, 1'b0);
      send_word(3'(ptrt_pkg::OP_SET_PER + 3), 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                4'hF, 1'b1);

      // three tasks at the period extremes
      send_word(ptrt_pkg::OP_ADD, 32'd0, 8'hFF, 32'd0, 4'd0, 1'b0);
      send_word(ptrt_pkg::OP_ADD, 32'd0, 8'h01, 32'hFFFF_FFFF, 4'd0, 1'b1);
      send_word(ptrt_pkg::OP_ADD, 32'd0, 8'h80, 32'd100, 4'd0, 1'b0);
      send_word(ptrt_pkg::OP_RUN, 32'd0, 8'd0, 32'd0, 4'd0, 1'b0);
      send_word(ptrt_pkg::OP_RUN, 32'hFFFF_FFFF, 8'd0, 32'd0, 4'd0, 1'b0);

      // wrapped due times, then a disabled task
      send_word(ptrt_pkg::OP_SET_PER, 32'd0, 8'd0, 32'd2, 4'd1, 1'b0);
      send_word(ptrt_pkg::OP_RUN, 32'd5, 8'd0, 32'd0, 4'd0, 1'b0);
      send_word(ptrt_pkg::OP_SET_EN, 32'd0, 8'd0, 32'd0, 4'd0, 1'b0);
      send_word(ptrt_pkg::OP_RUN, 32'h7FFF_FFFF, 8'd0, 32'd0, 4'd0, 1'b0);
      send_word(ptrt_pkg::OP_SET_EN, 32'd0, 8'd0, 32'd0, 4'd15, 1'b1);

      // fill the table, overflow it, release every entry at once
      for (int i = 0; i < 14; i++)
         send_word(ptrt_pkg::OP_ADD, 32'd0, 8'(8'h10 + i), 32'(i), 4'd0, 1'b1);
      send_word(ptrt_pkg::OP_SET_EN, 32'd0, 8'd0, 32'd0, 4'd0, 1'b1);
      send_word(ptrt_pkg::OP_RUN, 32'hFFFF_FFFF, 8'd0, 32'd0, 4'd0, 1'b0);
      send_word(ptrt_pkg::OP_REMOVE, 32'd0, 8'd0, 32'd0, 4'd15, 1'b0);
      send_word(ptrt_pkg::OP_REMOVE, 32'd0, 8'd0, 32'd0, 4'd0, 1'b0);

      // random traffic, busy sender against a slow receiver
      repeat (40) send_random_word();

      // the other way round
      send_idle_pct <= 85;
      take_idle_pct <= 24;
      repeat (40) send_random_word();

      // no idling; long receiver hold-off while words keep coming
      send_idle_pct <= 0;
      take_idle_pct <= 0;
      hold_toggle   <= 1'b1;
      for (int i = 0; i < 12; i++) begin
         sim_ms = sim_ms + 200;
         if (i % 3 == 0)
            send_word(ptrt_pkg::OP_ADD, sim_ms, 8'(8'h40 + i), 32'd50, 4'd0, 1'b1);
         else
            send_word(ptrt_pkg::OP_RUN, sim_ms, 8'd0, 32'd0, 4'd0, 1'b0);
      end
      repeat (25) send_random_word();
      req_ch.valid <= 1'b0;

      // drain the responses, then a short quiet stretch
      @(posedge clock);
      guard = 0;
      while (pending_words != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_words == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
